// ----- design/qmul_pkg.sv -----
`default_nettype none

package qmul_pkg;

   // Component format: signed Q2.14.
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 14;

   // One product, a sum of two products, and the full sum of four products.
   localparam int PROD_W = 2 * DATA_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   // Width of a sum after the rounding shift.
   localparam int RND_W = SUM_W - FRAC_BITS;

   localparam int NUM_COMP = 4;

   // Component order inside the arrays.
   localparam int COMP_W = 0;
   localparam int COMP_X = 1;
   localparam int COMP_Y = 2;
   localparam int COMP_Z = 3;

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0] RND_MAX    = RND_W'((1 <<< (DATA_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] RND_MIN    = -RND_W'(1 <<< (DATA_W - 1));

   typedef logic signed [DATA_W-1:0] comp_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [RND_W-1:0]  rnd_type;

   typedef struct packed {
      logic     clip;
      comp_type value;
   } sat_type;

   // Clamp a rounded sum to the component range and report whether it clamped.
   function automatic sat_type saturate(input rnd_type r);
      sat_type res;
      if (r > RND_MAX) begin
         res.clip  = 1'b1;
         res.value = RND_MAX[DATA_W-1:0];
      end else if (r < RND_MIN) begin
         res.clip  = 1'b1;
         res.value = RND_MIN[DATA_W-1:0];
      end else begin
         res.clip  = 1'b0;
         res.value = r[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/quaternion_multiply.sv -----
`default_nettype none

// Hamilton product p = a * b of two quaternions with signed Q2.14 components.
// Each output component is the exact sum of four products, rounded to nearest
// (halfway toward plus infinity) back to Q2.14 and saturated to 16 bits;
// rsp_clipped flags a result in which any component saturated. The datapath is
// a four-stage pipeline (products, pairwise sums, final sum and rounding,
// saturation into the output register), so an accepted request passes through
// every stage register before rsp_valid; one request can be taken every
// cycle while req_stall is low. A stalled result holds the output register,
// and req_stall rises only once every stage behind it is occupied; empty
// stages are filled while the output waits.
module quaternion_multiply
   import qmul_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic signed [DATA_W-1:0] req_a_w,
   input  wire logic signed [DATA_W-1:0] req_a_x,
   input  wire logic signed [DATA_W-1:0] req_a_y,
   input  wire logic signed [DATA_W-1:0] req_a_z,
   input  wire logic signed [DATA_W-1:0] req_b_w,
   input  wire logic signed [DATA_W-1:0] req_b_x,
   input  wire logic signed [DATA_W-1:0] req_b_y,
   input  wire logic signed [DATA_W-1:0] req_b_z,

   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [DATA_W-1:0] rsp_p_w,
   output      logic signed [DATA_W-1:0] rsp_p_x,
   output      logic signed [DATA_W-1:0] rsp_p_y,
   output      logic signed [DATA_W-1:0] rsp_p_z,
   output      logic                     rsp_clipped
);

   comp_type a_comp [NUM_COMP];
   comp_type b_comp [NUM_COMP];

   // Stage valid bits and advance enables.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic adv1, adv2, adv3, adv4;

   // Stage 1: all sixteen products a[i] * b[j].
   prod_type prod_ff [NUM_COMP][NUM_COMP];
   prod_type prod_in [NUM_COMP][NUM_COMP];

   // Stage 2: two partial sums per component.
   pair_type pair_lo_ff [NUM_COMP];
   pair_type pair_hi_ff [NUM_COMP];
   pair_type pair_lo_in [NUM_COMP];
   pair_type pair_hi_in [NUM_COMP];

   // Stage 3: rounded sums.
   rnd_type  rnd_ff [NUM_COMP];
   rnd_type  rnd_in [NUM_COMP];
   logic signed [SUM_W-1:0] sum_full [NUM_COMP];

   // Stage 4: output register.
   comp_type out_ff [NUM_COMP];
   comp_type out_in [NUM_COMP];
   logic     clip_ff, clip_in;
   sat_type  sat    [NUM_COMP];

   assign a_comp[COMP_W] = req_a_w;
   assign a_comp[COMP_X] = req_a_x;
   assign a_comp[COMP_Y] = req_a_y;
   assign a_comp[COMP_Z] = req_a_z;
   assign b_comp[COMP_W] = req_b_w;
   assign b_comp[COMP_X] = req_b_x;
   assign b_comp[COMP_Y] = req_b_y;
   assign b_comp[COMP_Z] = req_b_z;

   // A stage may load when it is empty or its contents move on this cycle.
   assign adv4 = !valid4_ff || !rsp_stall;
   assign adv3 = !valid3_ff || adv4;
   assign adv2 = !valid2_ff || adv3;
   assign adv1 = !valid1_ff || adv2;

   assign req_stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= req_valid;
         if (adv2) valid2_ff <= valid1_ff;
         if (adv3) valid3_ff <= valid2_ff;
         if (adv4) valid4_ff <= valid3_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         for (int j = 0; j < NUM_COMP; j++) begin
            prod_in[i][j] = PROD_W'(a_comp[i]) * PROD_W'(b_comp[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         prod_ff <= prod_in;
      end
   end

   // Signs follow i*j = k, j*k = i, k*i = j and i*i = j*j = k*k = -1.
   always_comb begin
      pair_lo_in[COMP_W] = PAIR_W'(prod_ff[COMP_W][COMP_W]) - PAIR_W'(prod_ff[COMP_X][COMP_X]);
      pair_hi_in[COMP_W] = -(PAIR_W'(prod_ff[COMP_Y][COMP_Y]) + PAIR_W'(prod_ff[COMP_Z][COMP_Z]));
      pair_lo_in[COMP_X] = PAIR_W'(prod_ff[COMP_W][COMP_X]) + PAIR_W'(prod_ff[COMP_X][COMP_W]);
      pair_hi_in[COMP_X] = PAIR_W'(prod_ff[COMP_Y][COMP_Z]) - PAIR_W'(prod_ff[COMP_Z][COMP_Y]);
      pair_lo_in[COMP_Y] = PAIR_W'(prod_ff[COMP_W][COMP_Y]) - PAIR_W'(prod_ff[COMP_X][COMP_Z]);
      pair_hi_in[COMP_Y] = PAIR_W'(prod_ff[COMP_Y][COMP_W]) + PAIR_W'(prod_ff[COMP_Z][COMP_X]);
      pair_lo_in[COMP_Z] = PAIR_W'(prod_ff[COMP_W][COMP_Z]) + PAIR_W'(prod_ff[COMP_X][COMP_Y]);
      pair_hi_in[COMP_Z] = PAIR_W'(prod_ff[COMP_Z][COMP_W]) - PAIR_W'(prod_ff[COMP_Y][COMP_X]);
   end

   always_ff @(posedge clock) begin
      if (adv2 && valid1_ff) begin
         pair_lo_ff <= pair_lo_in;
         pair_hi_ff <= pair_hi_in;
      end
   end

   // The arithmetic shift is just a selection of the upper bits of the sum.
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         sum_full[c] = SUM_W'(pair_lo_ff[c]) + SUM_W'(pair_hi_ff[c]) + ROUND_BIAS;
         rnd_in[c]   = sum_full[c][SUM_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && valid2_ff) begin
         rnd_ff <= rnd_in;
      end
   end

   always_comb begin
      clip_in = 1'b0;
      for (int c = 0; c < NUM_COMP; c++) begin
         sat[c]    = saturate(rnd_ff[c]);
         out_in[c] = sat[c].value;
         clip_in   = clip_in | sat[c].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4 && valid3_ff) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = valid4_ff;
   assign rsp_p_w     = out_ff[COMP_W];
   assign rsp_p_x     = out_ff[COMP_X];
   assign rsp_p_y     = out_ff[COMP_Y];
   assign rsp_p_z     = out_ff[COMP_Z];
   assign rsp_clipped = clip_ff;

   // The input side can only be held off when the whole pipeline is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid1_ff && valid2_ff && valid3_ff && valid4_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   // A request accepted while the output side runs free passes through every stage register to rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && !req_stall && !reset, 4) && !$past(reset, 3) && !$past(reset, 2)
       && !$past(reset, 1) && !$past(rsp_stall, 3) && !$past(rsp_stall, 2)
       && !$past(rsp_stall, 1)) |-> rsp_valid)
      else $error("accepted request did not reach the output in four cycles");

   // A clipped result must carry at least one component at a range limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_p_w == RND_MAX[DATA_W-1:0] || rsp_p_w == RND_MIN[DATA_W-1:0] ||
          rsp_p_x == RND_MAX[DATA_W-1:0] || rsp_p_x == RND_MIN[DATA_W-1:0] ||
          rsp_p_y == RND_MAX[DATA_W-1:0] || rsp_p_y == RND_MIN[DATA_W-1:0] ||
          rsp_p_z == RND_MAX[DATA_W-1:0] || rsp_p_z == RND_MIN[DATA_W-1:0]))
      else $error("clip flag set with no saturated component");

endmodule

`default_nettype wire
